// ----- hw/rtl/sha256_stream_hasher_assert.svh -----
// assertion macros for the sha-256 stream hasher
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SHS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define SHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/shs_pkg.sv -----
// shared types, constants and sha-256 functions for the stream hasher
package shs_pkg;

   typedef logic [31:0] word_type;
   // element 0 is word a, element 7 is word h
   typedef logic [7:0][31:0] hash_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic       wr_en;
      logic       shift;
      logic [5:0] wr_ptr;
      logic [7:0] wr_byte;
   } sched_ctrl_type;

   localparam hash_type HASH_INIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [5:0] LAST_BYTE  = 6'd63;
   localparam logic [5:0] LEN_START  = 6'd56;
   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [2:0] LAST_WORD  = 3'd7;

   function automatic word_type big_sig0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sig1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sig0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sig1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage

// ----- hw/rtl/sha256_stream_hasher.sv -----
// sha-256 stream hasher top level: byte intake, padding, round sequencer, digest output
//
//  channel  dir  handshake                tdata             tuser          tlast
//  req_     in   req_tvalid/req_tready    data_byte [7:0]   byte_present   end_of_message
//  rsp_     out  rsp_tvalid/rsp_tready    digest_word       word_number    last_word
//
// byte words are taken one per cycle while idle; the 64th byte of a block starts compression (64 rounds
// through the single round unit, then the hash fold)
// an end mark adds the padding fill, one byte per cycle from the mark to the block end,
// then the compression, twice when the padding spills over
// the eight digest words then leave one per accepted rsp_ word; rsp_tready low holds them
// req_tready is high only while idle; reset is synchronous and loads the initial hash
`include "sha256_stream_hasher_assert.svh"

module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_number
   output logic        rsp_tlast    // last_word
);
   import shs_pkg::*;

   // control and hash state
   state_type   state_ff,  state_in;
   hash_type    hash_ff,   hash_in;
   hash_type    work_ff,   work_in;
   logic [60:0] cnt_ff,    cnt_in;     // message bytes, wraps at 2^61
   logic [5:0]  rnd_ff,    rnd_in;
   logic [5:0]  ptr_ff,    ptr_in;     // padding write position
   logic        pad_ff,    pad_in;     // end mark taken, digest pending
   logic        first_ff,  first_in;   // next padding byte is the 0x80 mark
   logic        final_ff,  final_in;   // current padding block carries the length
   logic [2:0]  widx_ff,   widx_in;    // digest word being sent

   sched_ctrl_type sched_ctrl;
   word_type       w_cur;
   hash_type       round_out;

   logic [5:0]  pos;
   logic [5:0]  pad_start;
   logic [63:0] len_bits;
   logic [7:0]  len_byte;
   logic [7:0]  pad_byte;

   shs_sched u_sched (
      .clock (clock),
      .ctrl  (sched_ctrl),
      .w_cur (w_cur)
   );

   shs_round u_round (
      .v      (work_ff),
      .k      (round_k(rnd_ff)),
      .w      (w_cur),
      .v_next (round_out)
   );

   // padding byte: the mark, then zeros, then the big-endian bit length in the last eight
   always_comb begin
      pos       = cnt_ff[5:0];
      pad_start = req_tuser ? (pos + 6'd1) : pos;
      len_bits  = {cnt_ff, 3'b000};
      len_byte  = len_bits[{~ptr_ff[2:0], 3'b000} +: 8];
      if (first_ff) begin
         pad_byte = PAD_MARK;
      end else if (final_ff && (ptr_ff >= LEN_START)) begin
         pad_byte = len_byte;
      end else begin
         pad_byte = 8'h00;
      end
   end

   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      work_in  = work_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      ptr_in   = ptr_ff;
      pad_in   = pad_ff;
      first_in = first_ff;
      final_in = final_ff;
      widx_in  = widx_ff;

      sched_ctrl = '{wr_en: 1'b0, shift: 1'b0, wr_ptr: pos, wr_byte: req_tdata};

      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tdata  = hash_ff[widx_ff];
      rsp_tuser  = widx_ff;
      rsp_tlast  = (widx_ff == LAST_WORD);

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser) begin
                  sched_ctrl.wr_en = 1'b1;
                  cnt_in = cnt_ff + 61'd1;
               end
               pad_in   = req_tlast;
               first_in = 1'b1;
               if (req_tuser && (pos == LAST_BYTE)) begin
                  // block full: compress first; on an end mark the padding follows in a fresh block
                  state_in = ST_ROUND;
                  work_in  = hash_ff;
                  rnd_in   = '0;
                  final_in = 1'b0;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
                  ptr_in   = pad_start;
                  final_in = (pad_start < LEN_START);
               end
            end
         end

         ST_PAD: begin
            sched_ctrl.wr_en   = 1'b1;
            sched_ctrl.wr_ptr  = ptr_ff;
            sched_ctrl.wr_byte = pad_byte;
            first_in = 1'b0;
            ptr_in   = ptr_ff + 6'd1;
            if (ptr_ff == LAST_BYTE) begin
               state_in = ST_ROUND;
               work_in  = hash_ff;
               rnd_in   = '0;
            end
         end

         ST_ROUND: begin
            sched_ctrl.shift = 1'b1;
            work_in = round_out;
            rnd_in  = rnd_ff + 6'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end

         ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
            priority if (!pad_ff) begin
               state_in = ST_IDLE;
            end else if (final_ff) begin
               state_in = ST_SEND;
               widx_in  = '0;
            end else begin
               // padding spills over: one more block holding zeros and the length, led by the mark if still due
               state_in = ST_PAD;
               ptr_in   = '0;
               final_in = 1'b1;
            end
         end

         ST_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == LAST_WORD) begin
                  state_in = ST_IDLE;
                  hash_in  = HASH_INIT;
                  cnt_in   = '0;
                  pad_in   = 1'b0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hash_ff  <= HASH_INIT;
         cnt_ff   <= '0;
         rnd_ff   <= '0;
         ptr_ff   <= '0;
         pad_ff   <= 1'b0;
         first_ff <= 1'b0;
         final_ff <= 1'b0;
         widx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         cnt_ff   <= cnt_in;
         rnd_ff   <= rnd_in;
         ptr_ff   <= ptr_in;
         pad_ff   <= pad_in;
         first_ff <= first_in;
         final_ff <= final_in;
         widx_ff  <= widx_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   // input and output sides never open together
   `SHS_ASSERT_SAME(a_ready_excl, clock, reset, req_tready, !rsp_tvalid,
      "ready while sending digest")
   // after the last digest word the next message starts from a fresh state
   `SHS_ASSERT_NEXT(a_fresh_state, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
      (hash_ff == HASH_INIT) && (cnt_ff == '0) && !pad_ff,
      "state not restored after digest")
   // the final round always hands over to the hash fold
   `SHS_ASSERT_NEXT(a_round_to_fold, clock, reset,
      (state_ff == ST_ROUND) && (rnd_ff == LAST_ROUND), state_ff == ST_FOLD,
      "last round not followed by fold")

endmodule

// ----- hw/rtl/shs_round.sv -----
// one sha-256 compression round, shared over all 64 rounds of a block
module shs_round (
   input  shs_pkg::hash_type v,
   input  shs_pkg::word_type k,
   input  shs_pkg::word_type w,
   output shs_pkg::hash_type v_next
);
   import shs_pkg::*;

   word_type ch;
   word_type maj;
   word_type t1;
   word_type t2;

   always_comb begin
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1  = v[7] + big_sig1(v[4]) + ch + k + w;
      t2  = big_sig0(v[0]) + maj;
      v_next[7] = v[6];
      v_next[6] = v[5];
      v_next[5] = v[4];
      v_next[4] = v[3] + t1;
      v_next[3] = v[2];
      v_next[2] = v[1];
      v_next[1] = v[0];
      v_next[0] = t1 + t2;
   end

endmodule

// ----- hw/rtl/shs_sched.sv -----
// block buffer and message schedule as a 16-word sliding window
module shs_sched (
   input  logic                   clock,
   input  shs_pkg::sched_ctrl_type ctrl,
   output shs_pkg::word_type       w_cur
);
   import shs_pkg::*;

   word_type win_ff [16];
   word_type win_in [16];
   word_type w_new;

   always_comb begin
      w_new = small_sig1(win_ff[14]) + win_ff[9] + small_sig0(win_ff[1]) + win_ff[0];
      win_in = win_ff;
      if (ctrl.shift) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = w_new;
      end else if (ctrl.wr_en) begin
         // byte 0 of a word is its most significant byte
         win_in[ctrl.wr_ptr[5:2]][{~ctrl.wr_ptr[1:0], 3'b000} +: 8] = ctrl.wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign w_cur = win_ff[0];

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for the sha-256 stream hasher with a digest predictor
module tb_top;
   import shs_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int WORD_TARGET  = 310;
   localparam int SETTLE_WAIT  = 50;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam word_type START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct {
      word_type   word;
      logic [2:0] num;
      logic       last;
   } digest_entry_type;

   class digest_scoreboard;
      word_type         hash_state [8];
      logic [7:0]       block_buf [64];
      logic [60:0]      byte_count;
      digest_entry_type digest_q [$];
      int               errors;
      int               checked;
      int               messages;

      function new();
         hash_state = START_HASH;
         foreach (block_buf[i]) block_buf[i] = 8'h00;
         byte_count = '0;
         errors     = 0;
         checked    = 0;
         messages   = 0;
      endfunction

      function word_type ror(word_type x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         word_type w [64];
         word_type v [8];
         word_type s0, s1, t1, t2;
         for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
         for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
         end
         v = hash_state;
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
      endfunction

      // accepted req_ word: absorb the byte, and on the end mark pad and queue the digest
      function void note_word(logic [7:0] data, logic present, logic eom);
         logic [5:0]       pos;
         logic [63:0]      bit_len;
         int               p;
         digest_entry_type entry;
         if (present) begin
            pos = byte_count[5:0];
            block_buf[pos] = data;
            byte_count = byte_count + 1'b1;
            if (pos == 6'd63) compress();
         end
         if (!eom) return;
         bit_len = {byte_count, 3'b000};
         p = byte_count[5:0];
         block_buf[p] = PAD_BYTE;
         p++;
         // length field no longer fits: close this block and pad a second one
         if (p > 56) begin
            while (p < 64) begin
               block_buf[p] = 8'h00;
               p++;
            end
            compress();
            p = 0;
         end
         while (p < 56) begin
            block_buf[p] = 8'h00;
            p++;
         end
         for (int i = 0; i < 8; i++) block_buf[56+i] = bit_len[63-8*i -: 8];
         compress();
         for (int i = 0; i < 8; i++) begin
            entry.word = hash_state[i];
            entry.num  = 3'(i);
            entry.last = (3'(i) == LAST_WORD);
            digest_q.push_back(entry);
         end
         hash_state = START_HASH;
         byte_count = '0;
         messages++;
      endfunction

      function void check_word(word_type data, logic [2:0] num, logic last);
         digest_entry_type want;
         checked++;
         if (digest_q.size() == 0) begin
            $display("%0t: unexpected digest word %h num %0d last %0b", $time, data, num, last);
            errors++;
            return;
         end
         want = digest_q.pop_front();
         if (data !== want.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, want.word, data);
            errors++;
         end
         if (num !== want.num) begin
            $display("%0t: word_number expected %0d actual %0d", $time, want.num, num);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last_word expected %0b actual %0b", $time, want.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return digest_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] byte_present
   logic        req_tlast = 1'b0;    // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [31:0] digest_word
   logic [2:0]  rsp_tuser;           // [2:0] word_number
   logic        rsp_tlast;           // last_word

   digest_scoreboard sb;
   int          cycle_count = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   int          ready_phase = 0;
   logic [15:0] ready_pattern = 16'hffff;

   sha256_stream_hasher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // digest side: check on handshake, then stall on a rotating pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      ready_phase = ready_phase + 1;
      if (ready_phase % 256 == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pattern = 16'hffff;
            1: ready_pattern = 16'h0101;
            default: ready_pattern = 16'($urandom) | 16'h0001;
         endcase
      end
      rsp_tready <= ready_pattern[ready_phase % 16];
   end

   // one req_ word; returns in the time step of its handshake with tvalid still high
   task automatic send_word(input logic [7:0] data, input logic present, input logic eom);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(40, 80);
         end else begin
            gap = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 20);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= present;
      req_tlast  <= eom;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sb.note_word(data, present, eom);
      if (present || eom) words_sent++;
   endtask

   // random bytes, a stray empty word now and then, end mark on the last byte or alone
   task automatic send_message(input int len, input bit end_on_byte);
      bit closing;
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
         closing = end_on_byte && (k == len - 1);
         send_word(8'($urandom), 1'b1, closing);
      end
      if (!end_on_byte || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      int len;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored word, empty message, single bytes at both extremes, short messages
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'hff, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      send_word(8'h55, 1'b1, 1'b0);
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'haa, 1'b1, 1'b0);
      send_word(8'hff, 1'b0, 1'b1);
      send_word(8'h00, 1'b0, 1'b1);
      wait_for_drain();

      // padding spill into a second block, then a length that just fits
      send_message($urandom_range(56, 63), $urandom_range(0, 1));
      wait_for_drain();
      send_message(55, $urandom_range(0, 1));

      while (words_sent < WORD_TARGET) begin
         case ($urandom_range(0, 9))
            6: len = $urandom_range(54, 56);
            7: len = $urandom_range(57, 63);
            8: len = $urandom_range(64, 66);
            9: len = $urandom_range(118, 130);
            default: len = $urandom_range(0, 12);
         endcase
         // keep the last message from running far past the word budget
         if (len > WORD_TARGET - words_sent) len = WORD_TARGET - words_sent;
         send_message(len, $urandom_range(0, 1));
         if ($urandom_range(0, 7) == 0) wait_for_drain();
      end

      wait_for_drain();
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("covered %0d messages from %0d req_ words, incl. empty and spilled padding",
               sb.messages, words_sent);
      $display("checked %0d digest words under random gaps and stalls", sb.checked);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d field errors, %0d digest words never seen", sb.errors, sb.pending());
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
